// ===== sv/rsz_pkg.sv =====
package rsz_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int SIDE_W      = 7;
  localparam int IDX_W       = 6;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int WGT_W       = WEIGHT_BITS + 1;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = 12;
  localparam int PIX_W       = 32;
  localparam int PROD_W      = 2 * SIDE_W;
  localparam int NUM_W       = 32;
  localparam int DEN_W       = 9;
  localparam int CNT_W       = 6;
  localparam int HSUM_W      = 8 + WGT_W;
  localparam int VSUM_W      = HSUM_W + WGT_W;

  localparam logic [2:0] CFG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_DEST_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DEST_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_RESIZE_MODE = 3'd4;

  localparam logic [1:0] MODE_STRETCH = 2'd0;
  localparam logic [1:0] MODE_COVER   = 2'd1;
  localparam logic [1:0] MODE_CONTAIN = 2'd2;
  localparam logic [1:0] MODE_CENTER  = 2'd3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  typedef enum logic [1:0] {
    DIV_SIZE,
    DIV_X,
    DIV_Y
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_SDIV_GO,
    ST_SDIV_WAIT,
    ST_SIZE,
    ST_XDIV_GO,
    ST_XDIV_WAIT,
    ST_YDIV_GO,
    ST_YDIV_WAIT,
    ST_COORD,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_HORZ,
    ST_VERT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     cap_req;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_size;
    logic     cap_qx;
    logic     cap_coord;
    logic [1:0] rd_sel;
    logic     cap_pix;
    logic [1:0] pix_idx;
    logic     cap_horz;
    logic     cap_vert;
  } cmd_t;

  typedef struct packed {
    logic need_sdiv;
    logic oor;
    logic copy;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [IDX_W-1:0] i0;
    logic [IDX_W-1:0] i1;
    logic [WGT_W-1:0] w;
  } axis_t;

  function automatic logic [SIDE_W-1:0] sat_src(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] sat_dest(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  // source position in q.frac -> neighbour indexes and weight
  function automatic axis_t axis_map(input logic [NUM_W-1:0] q, input logic [SIDE_W-1:0] n);
    logic [NUM_W-1:0] half;
    logic [NUM_W-1:0] top;
    logic [NUM_W-1:0] t;
    logic [FRAC_BITS:0] wsum;
    logic [SIDE_W-1:0] nxt;
    axis_t r;
    half = NUM_W'(1) << (FRAC_BITS - 1);
    top  = NUM_W'(n - SIDE_W'(1)) << FRAC_BITS;
    t    = (q < half) ? '0 : q - half;
    if (t > top) t = top;
    r.i0 = t[FRAC_BITS +: IDX_W];
    wsum = {1'b0, t[FRAC_BITS-1:0]} + ((FRAC_BITS+1)'(1) << (FRAC_BITS - WEIGHT_BITS - 1));
    r.w  = wsum[FRAC_BITS -: WGT_W];
    nxt  = {1'b0, r.i0} + SIDE_W'(1);
    r.i1 = (nxt < n) ? nxt[IDX_W-1:0] : IDX_W'(n - SIDE_W'(1));
    return r;
  endfunction

endpackage

// ===== sv/rsz_ram.sv =====
module rsz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/rsz_div.sv =====
module rsz_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [rsz_pkg::NUM_W-1:0] num,
  input  logic [rsz_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [rsz_pkg::NUM_W-1:0] quo
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [rsz_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rsz_pkg::NUM_W-1:0] nq_r, nq_nxt;
  logic [rsz_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [rsz_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [rsz_pkg::DEN_W:0]   trial;
  logic [rsz_pkg::DEN_W:0]   diff;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, nq_r[rsz_pkg::NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rsz_pkg::CNT_W'(rsz_pkg::NUM_W);
      nq_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[rsz_pkg::DEN_W-1:0];
        nq_nxt  = {nq_r[rsz_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rsz_pkg::DEN_W-1:0];
        nq_nxt  = {nq_r[rsz_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - rsz_pkg::CNT_W'(1);
      if (cnt_r == rsz_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

// ===== sv/rsz_ctrl.sv =====
module rsz_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rsz_pkg::sts_t sts,
  output rsz_pkg::cmd_t cmd
);

  rsz_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsz_pkg::ST_IDLE: begin
        if (in_valid && in_func == rsz_pkg::FUNC_REQ) state_nxt = rsz_pkg::ST_PREP;
      end
      rsz_pkg::ST_PREP: begin
        state_nxt = sts.need_sdiv ? rsz_pkg::ST_SDIV_GO : rsz_pkg::ST_SIZE;
      end
      rsz_pkg::ST_SDIV_GO:   state_nxt = rsz_pkg::ST_SDIV_WAIT;
      rsz_pkg::ST_SDIV_WAIT: begin
        if (sts.div_done) state_nxt = rsz_pkg::ST_SIZE;
      end
      rsz_pkg::ST_SIZE: begin
        if (sts.oor) state_nxt = rsz_pkg::ST_OUT;
        else if (sts.copy) state_nxt = rsz_pkg::ST_COORD;
        else state_nxt = rsz_pkg::ST_XDIV_GO;
      end
      rsz_pkg::ST_XDIV_GO:   state_nxt = rsz_pkg::ST_XDIV_WAIT;
      rsz_pkg::ST_XDIV_WAIT: begin
        if (sts.div_done) state_nxt = rsz_pkg::ST_YDIV_GO;
      end
      rsz_pkg::ST_YDIV_GO:   state_nxt = rsz_pkg::ST_YDIV_WAIT;
      rsz_pkg::ST_YDIV_WAIT: begin
        if (sts.div_done) state_nxt = rsz_pkg::ST_COORD;
      end
      rsz_pkg::ST_COORD: state_nxt = rsz_pkg::ST_RD0;
      rsz_pkg::ST_RD0:   state_nxt = rsz_pkg::ST_RD1;
      rsz_pkg::ST_RD1:   state_nxt = rsz_pkg::ST_RD2;
      rsz_pkg::ST_RD2:   state_nxt = rsz_pkg::ST_RD3;
      rsz_pkg::ST_RD3:   state_nxt = rsz_pkg::ST_RD4;
      rsz_pkg::ST_RD4:   state_nxt = rsz_pkg::ST_HORZ;
      rsz_pkg::ST_HORZ:  state_nxt = rsz_pkg::ST_VERT;
      rsz_pkg::ST_VERT:  state_nxt = rsz_pkg::ST_OUT;
      rsz_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = rsz_pkg::ST_IDLE;
      end
      default: state_nxt = rsz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.div_sel = rsz_pkg::DIV_SIZE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      rsz_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.cap_req = in_valid && in_func == rsz_pkg::FUNC_REQ;
      end
      rsz_pkg::ST_SDIV_GO: cmd.div_go = 1'b1;
      rsz_pkg::ST_SIZE:    cmd.cap_size = 1'b1;
      rsz_pkg::ST_XDIV_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = rsz_pkg::DIV_X;
      end
      rsz_pkg::ST_XDIV_WAIT: cmd.cap_qx = sts.div_done;
      rsz_pkg::ST_YDIV_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = rsz_pkg::DIV_Y;
      end
      rsz_pkg::ST_COORD: cmd.cap_coord = 1'b1;
      rsz_pkg::ST_RD0: cmd.rd_sel = 2'd0;
      rsz_pkg::ST_RD1: begin
        cmd.rd_sel  = 2'd1;
        cmd.cap_pix = 1'b1;
        cmd.pix_idx = 2'd0;
      end
      rsz_pkg::ST_RD2: begin
        cmd.rd_sel  = 2'd2;
        cmd.cap_pix = 1'b1;
        cmd.pix_idx = 2'd1;
      end
      rsz_pkg::ST_RD3: begin
        cmd.rd_sel  = 2'd3;
        cmd.cap_pix = 1'b1;
        cmd.pix_idx = 2'd2;
      end
      rsz_pkg::ST_RD4: begin
        cmd.cap_pix = 1'b1;
        cmd.pix_idx = 2'd3;
      end
      rsz_pkg::ST_HORZ: cmd.cap_horz = 1'b1;
      rsz_pkg::ST_VERT: cmd.cap_vert = 1'b1;
      rsz_pkg::ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsz_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/rsz_dp.sv =====
module rsz_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rsz_pkg::SIDE_W-1:0] src_width,
  input  logic [rsz_pkg::SIDE_W-1:0] src_height,
  input  logic [rsz_pkg::SIDE_W-1:0] dest_width,
  input  logic [rsz_pkg::SIDE_W-1:0] dest_height,
  input  logic [1:0]                 resize_mode,
  input  logic [rsz_pkg::IDX_W-1:0]  dest_x,
  input  logic [rsz_pkg::IDX_W-1:0]  dest_y,
  input  logic                       ld_we,
  input  logic [rsz_pkg::ADDR_W-1:0] ld_addr,
  input  logic [rsz_pkg::PIX_W-1:0]  ld_data,
  input  rsz_pkg::cmd_t              cmd,
  output rsz_pkg::sts_t              sts,
  output logic [rsz_pkg::PIX_W-1:0]  pixel_out,
  output logic [rsz_pkg::SIDE_W-1:0] out_width,
  output logic [rsz_pkg::SIDE_W-1:0] out_height,
  output logic                       out_of_range
);

  localparam int SW = rsz_pkg::SIDE_W;
  localparam int IW = rsz_pkg::IDX_W;
  localparam int NW = rsz_pkg::NUM_W;
  localparam int DW = rsz_pkg::DEN_W;
  localparam int PW = rsz_pkg::PROD_W;
  localparam int WW = rsz_pkg::WGT_W;
  localparam int HW = rsz_pkg::HSUM_W;
  localparam int VW = rsz_pkg::VSUM_W;
  localparam logic [WW-1:0] WFULL = WW'(1) << rsz_pkg::WEIGHT_BITS;

  // request snapshot
  logic [SW-1:0] sw_r, sh_r, dw_r, dh_r;
  logic [PW-1:0] wq_r, hq_r;
  logic [IW-1:0] x_r, y_r;
  logic [1:0]    mode_r;
  // geometry
  logic [SW-1:0] ow_r, oh_r, cw_r, ch_r;
  logic [IW-1:0] cx_r, cy_r;
  logic          copy_r, oor_r;
  logic [NW-1:0] qx_r;
  logic [IW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [WW-1:0] wx_r, wy_r;
  logic [rsz_pkg::PIX_W-1:0] p_r [4];
  logic [HW-1:0] top_r [4];
  logic [HW-1:0] bot_r [4];
  logic [rsz_pkg::PIX_W-1:0] res_r;

  logic          empty, fits, wide, low;
  logic [NW-1:0] div_num, sdiv_num;
  logic [DW-1:0] div_den, sdiv_den;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [SW-1:0] ow_c, oh_c, cw_c, ch_c;
  logic [IW-1:0] cx_c, cy_c;
  logic          copy_c, oor_c;
  logic [SW-1:0] qs;
  rsz_pkg::axis_t ax, ay;
  logic [IW-1:0] row, col;
  logic [PW:0]   addr_full;
  logic [rsz_pkg::ADDR_W-1:0] rd_addr;
  logic [rsz_pkg::PIX_W-1:0]  rd_data;
  logic [HW-1:0] top_c [4];
  logic [HW-1:0] bot_c [4];
  logic [rsz_pkg::PIX_W-1:0] res_c;

  assign empty = (dw_r == '0) || (dh_r == '0);
  assign fits  = (mode_r == rsz_pkg::MODE_CENTER) && (sw_r <= dw_r) && (sh_r <= dh_r);
  assign wide  = wq_r >= hq_r;
  assign low   = wq_r <= hq_r;

  // size division: n/d rounded half up as (2n+d)/(2d)
  always_comb begin
    if (mode_r == rsz_pkg::MODE_COVER) begin
      sdiv_num = wide ? NW'({hq_r, 1'b0}) + NW'(dw_r) : NW'({wq_r, 1'b0}) + NW'(dh_r);
      sdiv_den = wide ? DW'({dw_r, 1'b0}) : DW'({dh_r, 1'b0});
    end else begin
      sdiv_num = low ? NW'({wq_r, 1'b0}) + NW'(sw_r) : NW'({hq_r, 1'b0}) + NW'(sh_r);
      sdiv_den = low ? DW'({sw_r, 1'b0}) : DW'({sh_r, 1'b0});
    end
  end

  // coordinate division: ((2d+1)*n << frac) / (2m), rounded half up
  always_comb begin
    case (cmd.div_sel)
      rsz_pkg::DIV_X: begin
        div_num = (NW'(PW'({x_r, 1'b1}) * PW'(cw_r)) << (rsz_pkg::FRAC_BITS + 1))
                  + NW'({ow_r, 1'b0});
        div_den = DW'({ow_r, 2'b00});
      end
      rsz_pkg::DIV_Y: begin
        div_num = (NW'(PW'({y_r, 1'b1}) * PW'(ch_r)) << (rsz_pkg::FRAC_BITS + 1))
                  + NW'({oh_r, 1'b0});
        div_den = DW'({oh_r, 2'b00});
      end
      default: begin
        div_num = sdiv_num;
        div_den = sdiv_den;
      end
    endcase
  end

  rsz_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign qs = (div_quo == '0) ? SW'(1) : div_quo[SW-1:0];

  always_comb begin
    ow_c   = dw_r;
    oh_c   = dh_r;
    cw_c   = sw_r;
    ch_c   = sh_r;
    copy_c = 1'b0;
    if (empty) begin
      ow_c = '0;
      oh_c = '0;
    end else begin
      case (mode_r)
        rsz_pkg::MODE_STRETCH: ;
        rsz_pkg::MODE_COVER: begin
          if (wide) ch_c = (div_quo == '0) ? SW'(1) : (div_quo > NW'(sh_r)) ? sh_r : qs;
          else      cw_c = (div_quo == '0) ? SW'(1) : (div_quo > NW'(sw_r)) ? sw_r : qs;
        end
        default: begin
          if (fits) begin
            copy_c = 1'b1;
            ow_c   = sw_r;
            oh_c   = sh_r;
          end else if (low) begin
            oh_c = qs;
          end else begin
            ow_c = qs;
          end
        end
      endcase
    end
    cx_c  = IW'((sw_r - cw_c) >> 1);
    cy_c  = IW'((sh_r - ch_c) >> 1);
    oor_c = ({1'b0, x_r} >= ow_c) || ({1'b0, y_r} >= oh_c);
  end

  assign ax = rsz_pkg::axis_map(qx_r, cw_r);
  assign ay = rsz_pkg::axis_map(div_quo, ch_r);

  // neighbour order: top-left, top-right, bottom-left, bottom-right
  assign row       = cmd.rd_sel[1] ? y1_r : y0_r;
  assign col       = cmd.rd_sel[0] ? x1_r : x0_r;
  assign addr_full = (PW+1)'(PW'({1'b0, cy_r} + {1'b0, row}) * PW'(sw_r))
                     + (PW+1)'(cx_r) + (PW+1)'(col);
  assign rd_addr   = addr_full[rsz_pkg::ADDR_W-1:0];

  rsz_ram #(
    .WIDTH(rsz_pkg::PIX_W),
    .DEPTH(rsz_pkg::STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ld_we),
    .wr_addr(ld_addr),
    .wr_data(ld_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    logic [VW-1:0] v;
    logic [VW-1:0] vr;
    logic [VW-rsz_pkg::WEIGHT_BITS*2-1:0] vq;
    res_c = '0;
    for (int c = 0; c < 4; c++) begin
      top_c[c] = HW'(p_r[0][8*c +: 8]) * HW'(WFULL - wx_r)
                 + HW'(p_r[1][8*c +: 8]) * HW'(wx_r);
      bot_c[c] = HW'(p_r[2][8*c +: 8]) * HW'(WFULL - wx_r)
                 + HW'(p_r[3][8*c +: 8]) * HW'(wx_r);
      v  = VW'(top_r[c]) * VW'(WFULL - wy_r) + VW'(bot_r[c]) * VW'(wy_r);
      vr = v + (VW'(1) << (2 * rsz_pkg::WEIGHT_BITS - 1));
      vq = vr[VW-1 -: VW-2*rsz_pkg::WEIGHT_BITS];
      res_c[8*c +: 8] = (vq > 255) ? 8'hff : vq[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      sw_r   <= rsz_pkg::sat_src(src_width);
      sh_r   <= rsz_pkg::sat_src(src_height);
      dw_r   <= rsz_pkg::sat_dest(dest_width);
      dh_r   <= rsz_pkg::sat_dest(dest_height);
      wq_r   <= PW'(rsz_pkg::sat_dest(dest_width)) * PW'(rsz_pkg::sat_src(src_height));
      hq_r   <= PW'(rsz_pkg::sat_dest(dest_height)) * PW'(rsz_pkg::sat_src(src_width));
      x_r    <= dest_x;
      y_r    <= dest_y;
      mode_r <= resize_mode;
    end
    if (cmd.cap_size) begin
      ow_r   <= ow_c;
      oh_r   <= oh_c;
      cw_r   <= cw_c;
      ch_r   <= ch_c;
      cx_r   <= cx_c;
      cy_r   <= cy_c;
      copy_r <= copy_c;
      oor_r  <= oor_c;
      res_r  <= '0;
    end
    if (cmd.cap_qx) begin
      qx_r <= div_quo;
    end
    if (cmd.cap_coord) begin
      // a plain copy reads one word through the same path with zero weights
      if (copy_r) begin
        x0_r <= x_r;
        x1_r <= x_r;
        y0_r <= y_r;
        y1_r <= y_r;
        wx_r <= '0;
        wy_r <= '0;
      end else begin
        x0_r <= ax.i0;
        x1_r <= ax.i1;
        y0_r <= ay.i0;
        y1_r <= ay.i1;
        wx_r <= ax.w;
        wy_r <= ay.w;
      end
    end
    if (cmd.cap_pix) begin
      p_r[cmd.pix_idx] <= rd_data;
    end
    if (cmd.cap_horz) begin
      for (int c = 0; c < 4; c++) begin
        top_r[c] <= top_c[c];
        bot_r[c] <= bot_c[c];
      end
    end
    if (cmd.cap_vert) begin
      res_r <= res_c;
    end
  end

  assign sts.need_sdiv = !empty && (mode_r != rsz_pkg::MODE_STRETCH) && !fits;
  assign sts.oor       = oor_c;
  assign sts.copy      = copy_c;
  assign sts.div_done  = div_done;

  assign pixel_out    = res_r;
  assign out_width    = ow_r;
  assign out_height   = oh_r;
  assign out_of_range = oor_r;

endmodule

// ===== sv/bilinear_image_resizer_core.sv =====
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall   func, pixel_index, pixel_in, dest_x, dest_y
// out_     output     out_valid/out_stall pixel_out, out_width, out_height, out_of_range
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a load is accepted only while idle; a request runs to its result through up to three
// passes of the shared radix-2 divider (output size, x, y) and four sequential reads
// from the single-read-port pixel store, which rst_n does not clear.
// a request with no size division skips the first pass, a plain copy skips all three;
// out-of-range ones end at the size check. rst_n clears control and config registers.
// the result holds in the output register while out_stall is high; no new item is taken.
module bilinear_image_resizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [11:0] in_pixel_index,
  input  logic [31:0] in_pixel_in,
  input  logic [5:0]  in_dest_x,
  input  logic [5:0]  in_dest_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_out,
  output logic [6:0]  out_width,
  output logic [6:0]  out_height,
  output logic        out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0] src_width_r, src_height_r, dest_width_r, dest_height_r;
  logic [1:0] resize_mode_r;
  logic       ld_we;
  rsz_pkg::cmd_t cmd;
  rsz_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= 7'd64;
      src_height_r  <= 7'd64;
      dest_width_r  <= 7'd64;
      dest_height_r <= 7'd64;
      resize_mode_r <= rsz_pkg::MODE_STRETCH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsz_pkg::CFG_SRC_WIDTH:   src_width_r   <= cfg_data;
        rsz_pkg::CFG_SRC_HEIGHT:  src_height_r  <= cfg_data;
        rsz_pkg::CFG_DEST_WIDTH:  dest_width_r  <= cfg_data;
        rsz_pkg::CFG_DEST_HEIGHT: dest_height_r <= cfg_data;
        rsz_pkg::CFG_RESIZE_MODE: resize_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign ld_we = in_valid && !in_stall && (in_func == rsz_pkg::FUNC_LOAD);

  rsz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsz_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_width   (src_width_r),
    .src_height  (src_height_r),
    .dest_width  (dest_width_r),
    .dest_height (dest_height_r),
    .resize_mode (resize_mode_r),
    .dest_x      (in_dest_x),
    .dest_y      (in_dest_y),
    .ld_we       (ld_we),
    .ld_addr     (in_pixel_index),
    .ld_data     (in_pixel_in),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_out   (out_pixel_out),
    .out_width   (out_width),
    .out_height  (out_height),
    .out_of_range(out_of_range)
  );

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] pix;
    logic [6:0]  w;
    logic [6:0]  h;
    logic        oor;
  } pixel_result_t;

  typedef enum int {ROW_CFG, ROW_LOAD, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    int            a;
    logic [31:0]   d;
    logic [5:0]    x;
    logic [5:0]    y;
    bit            typed;
    pixel_result_t res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [11:0] in_pixel_index;
  logic [31:0] in_pixel_in;
  logic [5:0]  in_dest_x;
  logic [5:0]  in_dest_y;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_pixel_out;
  logic [6:0]  out_width;
  logic [6:0]  out_height;
  logic        out_of_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;

  bilinear_image_resizer_core uut (.*);

  // shadow of the block's registers and pixel store
  logic [31:0]   pix_mem [rsz_pkg::STORE_DEPTH];
  logic [6:0]    reg_sw, reg_sh, reg_dw, reg_dh;
  logic [1:0]    reg_mode;
  pixel_result_t pending_pixels[$];
  row_t          dir_rows[$];
  int            errors;
  bit            quiet;
  bit            long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned src_pos(int d, int n, int m);
    longint unsigned q, top;
    q = div_round((longint'(2 * d + 1) * n) << rsz_pkg::FRAC_BITS, 2 * m);
    top = longint'(n - 1) << rsz_pkg::FRAC_BITS;
    q = (q < (1 << (rsz_pkg::FRAC_BITS - 1))) ? 0 : q - (1 << (rsz_pkg::FRAC_BITS - 1));
    return (q > top) ? top : q;
  endfunction

  function automatic int side_src(logic [6:0] v);
    if (v == 0) return 1;
    return (v > rsz_pkg::MAX_SIDE) ? rsz_pkg::MAX_SIDE : int'(v);
  endfunction

  function automatic pixel_result_t resize_pixel(logic [5:0] x, logic [5:0] y);
    int sw, sh, dw, dh, ow, oh, cx, cy, cw, ch, x0, x1, y0, y1, sh8;
    longint unsigned wq, hq, qx, qy, wx, wy, a, b, c, e, v;
    bit copy;
    logic [31:0] p00, p01, p10, p11;
    pixel_result_t r;
    sw = side_src(reg_sw);
    sh = side_src(reg_sh);
    dw = (reg_dw > rsz_pkg::MAX_SIDE) ? rsz_pkg::MAX_SIDE : int'(reg_dw);
    dh = (reg_dh > rsz_pkg::MAX_SIDE) ? rsz_pkg::MAX_SIDE : int'(reg_dh);
    ow = 0; oh = 0; cx = 0; cy = 0; cw = sw; ch = sh; copy = 0;
    if (dw != 0 && dh != 0) begin
      wq = dw * sh;
      hq = dh * sw;
      if (reg_mode == rsz_pkg::MODE_STRETCH) begin
        ow = dw; oh = dh;
      end else if (reg_mode == rsz_pkg::MODE_COVER) begin
        ow = dw; oh = dh;
        if (wq >= hq) begin
          ch = int'(div_round(dh * sw, dw));
          if (ch < 1) ch = 1;
          if (ch > sh) ch = sh;
        end else begin
          cw = int'(div_round(dw * sh, dh));
          if (cw < 1) cw = 1;
          if (cw > sw) cw = sw;
        end
        cx = (sw - cw) / 2;
        cy = (sh - ch) / 2;
      end else if (reg_mode == rsz_pkg::MODE_CENTER && sw <= dw && sh <= dh) begin
        copy = 1; ow = sw; oh = sh;
      end else if (wq <= hq) begin
        ow = dw;
        oh = int'(div_round(sh * dw, sw));
        if (oh < 1) oh = 1;
      end else begin
        oh = dh;
        ow = int'(div_round(sw * dh, sh));
        if (ow < 1) ow = 1;
      end
    end
    r.w = ow[6:0];
    r.h = oh[6:0];
    r.oor = 1'b0;
    r.pix = '0;
    if (x >= ow || y >= oh) begin
      r.oor = 1'b1;
    end else if (copy) begin
      r.pix = pix_mem[(y * sw + x) % rsz_pkg::STORE_DEPTH];
    end else begin
      qx = src_pos(x, cw, ow);
      qy = src_pos(y, ch, oh);
      x0 = int'(qx >> rsz_pkg::FRAC_BITS);
      y0 = int'(qy >> rsz_pkg::FRAC_BITS);
      x1 = (x0 + 1 < cw) ? x0 + 1 : cw - 1;
      y1 = (y0 + 1 < ch) ? y0 + 1 : ch - 1;
      wx = ((qx & 16'hFFFF) + 128) >> 8;
      wy = ((qy & 16'hFFFF) + 128) >> 8;
      p00 = pix_mem[((cy + y0) * sw + cx + x0) % rsz_pkg::STORE_DEPTH];
      p01 = pix_mem[((cy + y0) * sw + cx + x1) % rsz_pkg::STORE_DEPTH];
      p10 = pix_mem[((cy + y1) * sw + cx + x0) % rsz_pkg::STORE_DEPTH];
      p11 = pix_mem[((cy + y1) * sw + cx + x1) % rsz_pkg::STORE_DEPTH];
      for (int k = 0; k < 4; k++) begin
        sh8 = 8 * k;
        a = (p00 >> sh8) & 255; b = (p01 >> sh8) & 255;
        c = (p10 >> sh8) & 255; e = (p11 >> sh8) & 255;
        v = (a * (256 - wx) + b * wx) * (256 - wy) + (c * (256 - wx) + e * wx) * wy;
        v = (v + 32768) >> 16;
        if (v > 255) v = 255;
        r.pix[sh8 +: 8] = v[7:0];
      end
    end
    return r;
  endfunction

  task automatic send_item(logic func, logic [11:0] idx, logic [31:0] pix,
                           logic [5:0] x, logic [5:0] y, bit typed, pixel_result_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_pixel_index <= idx;
    in_pixel_in    <= pix;
    in_dest_x      <= x;
    in_dest_y      <= y;
    do @(posedge clk); while (in_stall);
    if (func == rsz_pkg::FUNC_LOAD) pix_mem[idx] = pix;
    else pending_pixels.push_back(typed ? res : resize_pixel(x, y));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  // caller must lower cfg_valid afterward
  task automatic write_reg(logic [2:0] idx, logic [6:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rsz_pkg::CFG_SRC_WIDTH:   reg_sw = data;
      rsz_pkg::CFG_SRC_HEIGHT:  reg_sh = data;
      rsz_pkg::CFG_DEST_WIDTH:  reg_dw = data;
      rsz_pkg::CFG_DEST_HEIGHT: reg_dh = data;
      rsz_pkg::CFG_RESIZE_MODE: reg_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [6:0] sw, logic [6:0] sh, logic [6:0] dw,
                              logic [6:0] dh, logic [6:0] mode);
    write_reg(rsz_pkg::CFG_SRC_WIDTH, sw);
    write_reg(rsz_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(rsz_pkg::CFG_DEST_WIDTH, dw);
    write_reg(rsz_pkg::CFG_DEST_HEIGHT, dh);
    write_reg(rsz_pkg::CFG_RESIZE_MODE, mode);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(row_kind_t kind, int a, logic [31:0] d, logic [5:0] x,
                                  logic [5:0] y, bit typed, logic [31:0] ep, logic [6:0] ew,
                                  logic [6:0] eh, logic eo);
    row_t r;
    r.kind = kind; r.a = a; r.d = d; r.x = x; r.y = y; r.typed = typed;
    r.res.pix = ep; r.res.w = ew; r.res.h = eh; r.res.oor = eo;
    dir_rows.push_back(r);
  endfunction

  // out_stall driver: one wait drawn per result
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 16);
      if (long_hold) begin
        n = 400;
        long_hold = 0;
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_pixel_out !== exp_px.pix) begin
          $error("pixel_out expected %h got %h", exp_px.pix, out_pixel_out);
          errors++;
        end
        if (out_width !== exp_px.w) begin
          $error("out_width expected %0d got %0d", exp_px.w, out_width);
          errors++;
        end
        if (out_height !== exp_px.h) begin
          $error("out_height expected %0d got %0d", exp_px.h, out_height);
          errors++;
        end
        if (out_of_range !== exp_px.oor) begin
          $error("out_of_range expected %0d got %0d", exp_px.oor, out_of_range);
          errors++;
        end
      end
    end
  end

  initial begin
    pixel_result_t none;
    int ow, oh, reqs;
    logic [6:0] sw, sh, dw, dh;
    errors = 0;
    quiet = 1;
    long_hold = 0;
    none = '{pix: '0, w: '0, h: '0, oor: 1'b0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = rsz_pkg::FUNC_LOAD;
    in_pixel_index = '0;
    in_pixel_in = '0;
    in_dest_x = '0;
    in_dest_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_sw = 7'd64; reg_sh = 7'd64; reg_dw = 7'd64; reg_dh = 7'd64;
    reg_mode = rsz_pkg::MODE_STRETCH;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the low 256 entries; every random source below keeps width * height within them
    for (int i = 0; i < 256; i++)
      send_item(rsz_pkg::FUNC_LOAD, 12'(i), $urandom, '0, '0, 0, none);
    quiet = 0;

    add_row(ROW_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_LOAD, 4095, 32'h80FF_00AA, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 64, 64, 0);
    add_row(ROW_REQ, 0, 0, 63, 63, 1, 32'h80FF_00AA, 64, 64, 0);
    add_row(ROW_LOAD, 1, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 1, 0, 1, 32'h0000_0000, 64, 64, 0);
    // empty output
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    // downscale with cover crop
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_WIDTH, 16, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_HEIGHT, 16, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_WIDTH, 16, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_HEIGHT, 9, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_RESIZE_MODE, rsz_pkg::MODE_COVER, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 5, 4, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 16, 0, 1, 0, 16, 9, 1);
    add_row(ROW_CFG, rsz_pkg::CFG_RESIZE_MODE, rsz_pkg::MODE_CONTAIN, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 8, 8, 0, 0, 0, 0, 0);
    // center with a source that fits is a plain copy
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_WIDTH, 8, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_HEIGHT, 8, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_WIDTH, 64, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_HEIGHT, 64, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_RESIZE_MODE, 7'h7F, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 3, 7, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 8, 0, 1, 0, 8, 8, 1);
    // register values beyond range saturate; unknown index is ignored
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_SRC_HEIGHT, 127, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, rsz_pkg::CFG_DEST_WIDTH, 100, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_CFG, 7, 7'h55, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 63, 40, 0, 0, 0, 0, 0);
    add_row(ROW_REQ, 0, 0, 0, 63, 0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(3'(dir_rows[i].a), dir_rows[i].d[6:0]);
          @(negedge clk);
          cfg_valid <= 1'b0;
        end
        ROW_LOAD: send_item(rsz_pkg::FUNC_LOAD, 12'(dir_rows[i].a), dir_rows[i].d,
                            '0, '0, 0, none);
        default: send_item(rsz_pkg::FUNC_REQ, 12'($urandom), $urandom, dir_rows[i].x,
                           dir_rows[i].y, dir_rows[i].typed, dir_rows[i].res);
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      drain_results();
      sw = 7'($urandom_range(1, 64));
      sh = 7'($urandom_range(1, 256 / int'(sw)));
      dw = 7'($urandom_range(1, 64)); dh = 7'($urandom_range(1, 64));
      if (p == 0) begin sw = 1; sh = 1; dw = 64; dh = 64; end
      if (p == 1) begin sw = 64; sh = 4; dw = 1; dh = 1; end
      if (p == 6) dh = 0;
      set_geometry(sw, sh, dw, dh, 7'(p % 4));
      quiet = (p == 5);
      if (p == 3) long_hold = 1;
      ow = (dw > sw) ? dw : sw;
      oh = (dh > sh) ? dh : sh;
      reqs = 0;
      while (reqs < 42) begin
        if ($urandom_range(0, 9) < 3) begin
          send_item(rsz_pkg::FUNC_LOAD, 12'($urandom), $urandom, 6'($urandom),
                    6'($urandom), 0, none);
        end else begin
          // mostly inside the likely output, sometimes anywhere
          if ($urandom_range(0, 3) != 0)
            send_item(rsz_pkg::FUNC_REQ, 12'($urandom), $urandom,
                      6'($urandom_range(0, ow - 1)), 6'($urandom_range(0, oh - 1)), 0, none);
          else
            send_item(rsz_pkg::FUNC_REQ, 12'($urandom), $urandom, 6'($urandom),
                      6'($urandom), 0, none);
          reqs++;
        end
      end
    end
    quiet = 0;
    drain_results();

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rsz_pkg.sv
sv/rsz_ram.sv
sv/rsz_div.sv
sv/rsz_ctrl.sv
sv/rsz_dp.sv
sv/bilinear_image_resizer_core.sv
verif/tb.sv
